>>> rtl/hrp_pkg.sv
// shared types, codes and character tables of the http request parser
`default_nettype none
package hrp_pkg;

    // parser phases
    localparam logic [3:0] PH_METHOD    = 4'd0;
    localparam logic [3:0] PH_METHOD_SP = 4'd1;
    localparam logic [3:0] PH_URI       = 4'd2;
    localparam logic [3:0] PH_PATH      = 4'd3;
    localparam logic [3:0] PH_STAR_SP   = 4'd4;
    localparam logic [3:0] PH_VLIT      = 4'd5;
    localparam logic [3:0] PH_MAJOR     = 4'd6;
    localparam logic [3:0] PH_MINOR     = 4'd7;
    localparam logic [3:0] PH_HDR_START = 4'd8;
    localparam logic [3:0] PH_HDR_NAME  = 4'd9;
    localparam logic [3:0] PH_HOST_SKIP = 4'd10;
    localparam logic [3:0] PH_HOST_VAL  = 4'd11;
    localparam logic [3:0] PH_SKIP_VAL  = 4'd12;
    localparam logic [3:0] PH_BLANK_CR  = 4'd13;
    localparam logic [3:0] PH_RESYNC    = 4'd14;

    // event kinds
    localparam logic [2:0] EV_METHOD    = 3'd0;
    localparam logic [2:0] EV_PATH_BYTE = 3'd1;
    localparam logic [2:0] EV_PATH_END  = 3'd2;
    localparam logic [2:0] EV_LINE_OK   = 3'd3;
    localparam logic [2:0] EV_HOST_BYTE = 3'd4;
    localparam logic [2:0] EV_HOST_END  = 3'd5;
    localparam logic [2:0] EV_REQ_END   = 3'd6;
    localparam logic [2:0] EV_ERROR     = 3'd7;

    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam int NUM_METHODS = 8;
    localparam int VLIT_LEN    = 5;
    localparam int HOST_LEN    = 4;

    // method names, first character in the top byte, padded with spaces
    localparam logic [55:0] VERB_TEXT [NUM_METHODS] = '{
        "OPTIONS", "GET    ", "HEAD   ", "POST   ",
        "PUT    ", "DELETE ", "TRACE  ", "CONNECT"
    };
    localparam logic [2:0] VERB_LEN [NUM_METHODS] = '{
        3'd7, 3'd3, 3'd4, 3'd4, 3'd3, 3'd6, 3'd5, 3'd7
    };
    localparam logic [39:0] VLIT_TEXT = "HTTP/";
    localparam logic [31:0] HOST_TEXT = "Host";

    typedef struct packed {
        logic [3:0] phase;
        logic [7:0] live_mask;
        logic [2:0] char_index;
        logic [2:0] matched_method;
        logic       name_is_host;
        logic       header_seen;
    } hrp_state_t;

    typedef struct packed {
        logic       valid;
        logic [2:0] kind;
        logic [7:0] data;
    } hrp_event_t;

    localparam hrp_state_t STATE_RESET = '{
        phase: PH_METHOD, live_mask: 8'hFF, char_index: 3'd0,
        matched_method: 3'd0, name_is_host: 1'b1, header_seen: 1'b0
    };

    function automatic logic [7:0] verb_char(input logic [55:0] text, input logic [2:0] idx);
        logic [55:0] w;
        w = text << {idx, 3'b000};
        return w[55:48];
    endfunction

    function automatic logic [7:0] vlit_char(input logic [2:0] idx);
        logic [39:0] w;
        w = VLIT_TEXT << {idx, 3'b000};
        return w[39:32];
    endfunction

    function automatic logic [7:0] host_char(input logic [1:0] idx);
        logic [31:0] w;
        w = HOST_TEXT << {idx, 3'b000};
        return w[31:24];
    endfunction

endpackage
`default_nettype wire

>>> rtl/hrp_step.sv
// next-state and event logic of the parser for one byte
`default_nettype none
module hrp_step
    import hrp_pkg::*;
(
    input  hrp_state_t st,
    input  logic [7:0] data_byte,
    input  logic       end_of_input,
    output hrp_state_t nx,
    output hrp_event_t ev
);

    logic       err;
    logic       restart;
    logic       digit;
    logic [7:0] mask_new;
    logic       found;
    logic [2:0] found_m;
    logic       host_hit;

    assign digit = (data_byte >= CH_ZERO) && (data_byte <= CH_NINE);

    // method candidates that survive this byte
    always_comb begin
        mask_new = st.live_mask;
        for (int m = 0; m < NUM_METHODS; m++) begin
            if ((st.char_index >= VERB_LEN[m]) ||
                (data_byte != verb_char(VERB_TEXT[m], st.char_index))) begin
                mask_new[m] = 1'b0;
            end
        end
    end

    // lowest surviving method whose name ends here
    always_comb begin
        found   = 1'b0;
        found_m = 3'd0;
        for (int m = 0; m < NUM_METHODS; m++) begin
            if (!found && mask_new[m] && (VERB_LEN[m] == st.char_index + 3'd1)) begin
                found   = 1'b1;
                found_m = 3'(m);
            end
        end
    end

    assign host_hit = (st.char_index < 3'(HOST_LEN)) &&
                      (data_byte == host_char(st.char_index[1:0]));

    always_comb begin
        nx      = st;
        ev      = '0;
        err     = 1'b0;
        restart = 1'b0;

        unique case (st.phase)
            PH_METHOD: begin
                nx.live_mask = mask_new;
                if (mask_new == 8'h00) begin
                    err = 1'b1;
                end else if (found) begin
                    nx.matched_method = found_m;
                    ev.valid          = 1'b1;
                    ev.kind           = EV_METHOD;
                    nx.phase          = PH_METHOD_SP;
                    nx.char_index     = 3'd0;
                end else begin
                    nx.char_index = st.char_index + 3'd1;
                end
            end
            PH_METHOD_SP: begin
                if (data_byte == CH_SP) nx.phase = PH_URI;
                else err = 1'b1;
            end
            PH_URI: begin
                if (data_byte == CH_STAR) begin
                    nx.phase = PH_STAR_SP;
                end else if (data_byte == CH_SLASH) begin
                    ev       = '{valid: 1'b1, kind: EV_PATH_BYTE, data: data_byte};
                    nx.phase = PH_PATH;
                end else begin
                    err = 1'b1;
                end
            end
            PH_PATH: begin
                if (data_byte == CH_SP) begin
                    ev            = '{valid: 1'b1, kind: EV_PATH_END, data: 8'h00};
                    nx.phase      = PH_VLIT;
                    nx.char_index = 3'd0;
                end else if (data_byte == CH_LF) begin
                    err = 1'b1;
                end else begin
                    ev = '{valid: 1'b1, kind: EV_PATH_BYTE, data: data_byte};
                end
            end
            PH_STAR_SP: begin
                if (data_byte == CH_SP) begin
                    nx.phase      = PH_VLIT;
                    nx.char_index = 3'd0;
                end else begin
                    err = 1'b1;
                end
            end
            PH_VLIT: begin
                if ((st.char_index < 3'(VLIT_LEN)) &&
                    (data_byte == vlit_char(st.char_index))) begin
                    if (st.char_index == 3'(VLIT_LEN - 1)) begin
                        nx.phase      = PH_MAJOR;
                        nx.char_index = 3'd0;
                    end else begin
                        nx.char_index = st.char_index + 3'd1;
                    end
                end else begin
                    err = 1'b1;
                end
            end
            PH_MAJOR: begin
                if (data_byte == CH_DOT) nx.phase = PH_MINOR;
                else if (!digit) err = 1'b1;
            end
            PH_MINOR: begin
                if (data_byte == CH_LF) begin
                    ev             = '{valid: 1'b1, kind: EV_LINE_OK, data: 8'h00};
                    nx.phase       = PH_HDR_START;
                    nx.header_seen = 1'b0;
                end else if (!digit && data_byte != CH_CR) begin
                    err = 1'b1;
                end
            end
            PH_HDR_START: begin
                if (data_byte == CH_LF || data_byte == CH_CR) begin
                    if (!st.header_seen) begin
                        err = 1'b1;
                    end else if (data_byte == CH_LF) begin
                        ev      = '{valid: 1'b1, kind: EV_REQ_END, data: 8'h00};
                        restart = 1'b1;
                    end else begin
                        nx.phase = PH_BLANK_CR;
                    end
                end else if (data_byte == CH_COLON) begin
                    // empty name, value is skipped
                    nx.name_is_host = 1'b0;
                    nx.char_index   = 3'd0;
                    nx.phase        = PH_SKIP_VAL;
                end else begin
                    nx.name_is_host = (data_byte == host_char(2'd0));
                    nx.char_index   = 3'd1;
                    nx.phase        = PH_HDR_NAME;
                end
            end
            PH_HDR_NAME: begin
                if (data_byte == CH_COLON) begin
                    nx.phase = (st.name_is_host && st.char_index == 3'(HOST_LEN)) ?
                               PH_HOST_SKIP : PH_SKIP_VAL;
                    nx.char_index = 3'd0;
                end else if (data_byte == CH_LF) begin
                    err = 1'b1;
                end else begin
                    if (!host_hit) nx.name_is_host = 1'b0;
                    if (st.char_index < 3'(HOST_LEN)) nx.char_index = st.char_index + 3'd1;
                end
            end
            PH_HOST_SKIP: begin
                nx.phase = PH_HOST_VAL;
            end
            PH_HOST_VAL: begin
                if (data_byte == CH_LF) begin
                    ev             = '{valid: 1'b1, kind: EV_HOST_END, data: 8'h00};
                    nx.header_seen = 1'b1;
                    nx.phase       = PH_HDR_START;
                end else if (data_byte != CH_CR) begin
                    ev = '{valid: 1'b1, kind: EV_HOST_BYTE, data: data_byte};
                end
            end
            PH_SKIP_VAL: begin
                if (data_byte == CH_LF) begin
                    nx.header_seen = 1'b1;
                    nx.phase       = PH_HDR_START;
                end
            end
            PH_BLANK_CR: begin
                if (data_byte == CH_LF) begin
                    ev      = '{valid: 1'b1, kind: EV_REQ_END, data: 8'h00};
                    restart = 1'b1;
                end else begin
                    err = 1'b1;
                end
            end
            default: begin
                // resync: wait for the end of the bad line
                if (data_byte == CH_LF) restart = 1'b1;
            end
        endcase

        if (err) begin
            ev = '{valid: 1'b1, kind: EV_ERROR, data: 8'h00};
            if (data_byte == CH_LF) restart = 1'b1;
            else nx.phase = PH_RESYNC;
        end

        if (restart) begin
            nx.phase       = PH_METHOD;
            nx.live_mask   = 8'hFF;
            nx.char_index  = 3'd0;
            nx.header_seen = 1'b0;
        end

        if (end_of_input) nx = STATE_RESET;
    end

endmodule
`default_nettype wire

>>> rtl/http_request_parser_unit.sv
// top level of the http request parser: input register, parser state, result register
`default_nettype none
// Takes one byte of request text per transfer on the slave side and reports
// parse events on the master side. A new byte is taken every clock while the
// master side does not stall, and the sustained rate is one byte per cycle.
// A byte waits in the input register, and its event, if it has one, is then
// raised on m_tvalid from the result register. The rate is set by the
// parser's state register, whose next value comes from the byte-compare
// logic between the input register and the result register.
// Bytes that cause no event produce no transfer. A byte with tlast set is
// parsed normally and then returns the parser to its reset state. After an
// error the parser skips to the next LF before looking for a new request line.
module http_request_parser_unit
    import hrp_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    input  wire logic        s_tlast,   // end_of_input
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // [2:0] method_code, [10:3] byte_out, rest zero
    output logic [2:0]       m_tuser    // [2:0] event_res
);

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;
    hrp_state_t state_reg;
    hrp_state_t state_next;
    hrp_event_t ev_next;
    logic       out_valid_reg;
    logic [2:0] out_kind_reg;
    logic [2:0] out_method_reg;
    logic [7:0] out_byte_reg;
    logic       advance;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    hrp_step u_step (
        .st           (state_reg),
        .data_byte    (in_byte_reg),
        .end_of_input (in_last_reg),
        .nx           (state_next),
        .ev           (ev_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= STATE_RESET;
        end else begin
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                state_reg     <= state_next;
                out_valid_reg <= ev_next.valid;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        if (advance) begin
            out_kind_reg   <= ev_next.kind;
            out_method_reg <= state_next.matched_method;
            out_byte_reg   <= ev_next.data;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tdata  = {5'b00000, out_byte_reg, out_method_reg};

    // no byte value rides on events other than path and host bytes
    a_byte_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser != EV_PATH_BYTE && m_tuser != EV_HOST_BYTE)
        |-> (m_tdata[10:3] == 8'h00))
        else $error("byte_out set on a non-byte event");

    // an error leaves the parser resyncing or at a fresh line
    a_err_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && ev_next.valid && ev_next.kind == EV_ERROR)
        |=> (state_reg.phase == PH_RESYNC || state_reg.phase == PH_METHOD))
        else $error("error event without resync");

    // while matching a method at least one candidate is alive
    a_mask_live: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg.phase == PH_METHOD) |-> (state_reg.live_mask != 8'h00))
        else $error("method match with no candidate");

    // literal and name indexes stay inside their strings
    a_index_range: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg.phase == PH_VLIT) |-> (state_reg.char_index < 3'(VLIT_LEN))) and
        ((state_reg.phase == PH_HDR_NAME) |-> (state_reg.char_index <= 3'(HOST_LEN))))
        else $error("char index out of range");

    // a method event reports the method just matched
    a_method_sync: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && ev_next.valid && ev_next.kind == EV_METHOD && !in_last_reg)
        |=> (out_method_reg == state_reg.matched_method &&
             state_reg.phase == PH_METHOD_SP))
        else $error("method event out of step with state");

endmodule
`default_nettype wire
